// File: rtl/lsee_pkg.sv
`default_nettype none

package lsee_pkg;

   // strip size and field widths
   localparam int MaxLeds  = 12;
   localparam int LedCntW  = $clog2(MaxLeds + 1);
   localparam int LedIdxW  = 4;
   localparam int ColorW   = 24;
   localparam int TimeW    = 32;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;
   localparam int DivNumW  = 32;
   localparam int DivDenW  = 17;
   localparam int DivCntW  = $clog2(DivNumW + 1);

   // timing and level constants
   localparam logic [TimeW-1:0] StaticWaitMs  = 32'd300;
   localparam logic [TimeW-1:0] BreathFrameMs = 32'd5;
   localparam logic [7:0]       LevelMax      = 8'd255;
   localparam logic [7:0]       HalfStepDiv   = 8'd10;

   // x / 255 as (x * Recip255) >> Recip255Sh, exact for x below 2^24
   localparam logic [24:0] Recip255   = 25'd16843010;
   localparam int          Recip255Sh = 32;
   // p / 10 as (p * Recip10) >> Recip10Sh, exact for p below 2^22
   localparam logic [19:0] Recip10    = 20'd838861;
   localparam int          Recip10Sh  = 23;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // effect modes
   localparam logic [1:0] FX_STATIC    = 2'd0;
   localparam logic [1:0] FX_BREATH    = 2'd1;
   localparam logic [1:0] FX_WATERFALL = 2'd2;
   localparam logic [1:0] FX_FLICKER   = 2'd3;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_EFFECT_MODE  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_BREATH_MIN   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_BREATH_MAX   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_BREATH_PER   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PWM_LEVELS   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_STEP_WAIT    = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_LED_COUNT    = 3'd6;

   typedef struct packed {
      logic              command;
      logic [TimeW-1:0]  now_ms;
      logic [LedIdxW-1:0] led_index;
      logic [ColorW-1:0] led_color;
   } req_word_type;

   typedef struct packed {
      logic [LedIdxW-1:0] out_index;
      logic [ColorW-1:0]  out_color;
      logic               frame_last;
   } rsp_word_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;
      logic shift;
      logic is_last;
   } cell_ctl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// File: rtl/led_strip_effect_engine_unit.sv
`default_nettype none

// RGB LED strip effect engine: static, breath, waterfall and flicker frames.
// Command channel: req_word is taken on a clock edge with start high and
// busy low. A word is either a color write into the LED list (no result)
// or a millisecond tick. A tick that is not due gives no result. A due
// tick emits one frame, one rsp_word per LED in use in LED order, on
// rsp_strobe for one cycle each, frame_last marking the end. Busy stays
// high until the last word of the frame is registered; at most 12 LEDs are in use.
// A breath tick first works out the color, per channel: two level products
// scaled by a reciprocal multiply, then the ramp product on a 32-step serial
// divider (skipped when the period is under 10 ms and the ramp term is zero),
// then the frame as above.
// The LED list is a ring of cells that shifts once per emitted LED, but not
// after the last LED of a waterfall frame; in breath mode the breath color
// is shifted in. Static, waterfall and lit flicker frames read cell 0.
// Config port: csr_index/csr_data are written when csr_valid and csr_ready
// are high; csr_ready is high while the block is idle.
// Reset (synchronous) clears the list to black and loads the default
// registers. Results cannot be held off; the receiver must take each word.
module led_strip_effect_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  lsee_pkg::req_word_type          req_word,
   output logic                            rsp_strobe,
   output lsee_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lsee_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [lsee_pkg::CsrDataW-1:0]   csr_data
);
   import lsee_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SCALE,
      S_LAUNCH,
      S_DIV,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_LO,
      PH_HI,
      PH_RAMP
   } phase_type;

   localparam logic [1:0] LastChan = 2'd2;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         mode_ff, mode_in;
   logic [ColorW-1:0]  min_ff, min_in;
   logic [ColorW-1:0]  max_ff, max_in;
   logic [19:0]        period_ff, period_in;
   logic [15:0]        pwm_ff, pwm_in;
   logic [15:0]        wait_ff, wait_in;
   logic [3:0]         count_ff, count_in;
   logic [TimeW-1:0]   due_ff, due_in;
   logic [15:0]        step_ff, step_in;
   logic               rising_ff, rising_in;
   logic               flicker_ff, flicker_in;
   logic [1:0]         ch_ff, ch_in;
   logic [DivDenW-1:0] half_ff, half_in;
   logic [15:0]        lo_ff, lo_in;
   logic [15:0]        hi_ff, hi_in;
   logic [31:0]        prod_ff, prod_in;
   logic [ColorW-1:0]  bcolor_ff, bcolor_in;
   logic [LedCntW-1:0] n_ff, n_in;
   logic [LedCntW-1:0] cnt_ff, cnt_in;
   logic               black_ff, black_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               req_acc;
   logic               write_acc;
   logic               csr_acc;
   logic [TimeW-1:0]   due_add;
   logic [TimeW-1:0]   due_sum;
   logic [TimeW-1:0]   due_next;
   logic               tick_due;
   logic [LedCntW-1:0] leds_use;
   logic               emit_last;
   logic               emit_shift;
   logic [7:0]         chan_min;
   logic [7:0]         chan_max_raw;
   logic [7:0]         chan_max;
   logic [15:0]        mul_a;
   logic [15:0]        mul_b;
   logic [31:0]        mul_res;
   logic [39:0]        half_prod;
   logic [DivDenW-1:0] half_calc;
   logic [48:0]        scale_prod;
   logic [15:0]        lvl_scaled;
   logic               finish;
   logic [DivNumW-1:0] fin_q;
   logic [DivNumW:0]   level_sum;
   logic [7:0]         level;
   logic [15:0]        step_new;
   logic               div_start;
   logic [DivNumW-1:0] div_num;
   logic [DivDenW-1:0] div_den;
   logic [DivNumW-1:0] div_quo;
   div_stat_type       div_stat;
   logic [ColorW-1:0]  wrap_color;
   logic [ColorW-1:0]  cell_color [MaxLeds];
   cell_ctl_type       cell_ctl [MaxLeds];

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_acc   = start && !busy;
   assign write_acc = req_acc && (req_word.command == CMD_WRITE);
   assign csr_acc   = csr_valid && csr_ready;

   // leds in use, clamped to 1..MaxLeds
   always_comb begin
      if (count_ff == '0) begin
         leds_use = LedCntW'(1);
      end else if (int'(count_ff) > MaxLeds) begin
         leds_use = LedCntW'(MaxLeds);
      end else begin
         leds_use = LedCntW'(count_ff);
      end
   end

   // due test and next due time for the current mode
   always_comb begin
      case (mode_ff)
         FX_BREATH: begin
            due_add  = BreathFrameMs;
            due_next = req_word.now_ms;
         end
         FX_WATERFALL: begin
            due_add  = {16'b0, wait_ff};
            due_next = req_word.now_ms;
         end
         FX_FLICKER: begin
            due_add  = '0;
            due_next = req_word.now_ms + {16'b0, wait_ff};
         end
         default: begin
            due_add  = '0;
            due_next = req_word.now_ms + StaticWaitMs;
         end
      endcase
   end
   assign due_sum  = due_ff + due_add;
   assign tick_due = due_sum < req_word.now_ms;

   // channel of the breath colors being worked on
   always_comb begin
      case (ch_ff)
         2'd0: begin
            chan_min     = min_ff[23:16];
            chan_max_raw = max_ff[23:16];
         end
         2'd1: begin
            chan_min     = min_ff[15:8];
            chan_max_raw = max_ff[15:8];
         end
         default: begin
            chan_min     = min_ff[7:0];
            chan_max_raw = max_ff[7:0];
         end
      endcase
   end
   assign chan_max = (chan_max_raw < chan_min) ? 8'hFF : chan_max_raw;

   // shared multiplier: pwm levels times a channel, or step times the span
   always_comb begin
      case (phase_ff)
         PH_RAMP: begin
            mul_a = step_ff;
            mul_b = hi_ff - lo_ff;
         end
         PH_HI: begin
            mul_a = pwm_ff;
            mul_b = {8'b0, chan_max};
         end
         default: begin
            mul_a = pwm_ff;
            mul_b = {8'b0, chan_min};
         end
      endcase
   end
   assign mul_res = {16'b0, mul_a} * {16'b0, mul_b};

   // half steps = period / 10 and level = product / 255 by reciprocal multiply
   assign half_prod  = {20'b0, period_ff} * {20'b0, Recip10};
   assign half_calc  = half_prod[Recip10Sh +: DivDenW];
   assign scale_prod = {25'b0, prod_ff[23:0]} * {24'b0, Recip255};
   assign lvl_scaled = scale_prod[Recip255Sh +: 16];

   // divider operands: ramp product over half steps
   assign div_num = prod_ff;
   assign div_den = half_ff;

   assign emit_last  = (cnt_ff == LedCntW'(n_ff - 1'b1));
   assign emit_shift = (state_ff == S_EMIT) && !((mode_ff == FX_WATERFALL) && emit_last);
   assign wrap_color = (mode_ff == FX_BREATH) ? bcolor_ff : cell_color[0];

   // channel level: lo plus ramp term, clamped
   assign level_sum = {{(DivNumW + 1 - 16){1'b0}}, lo_ff} + {1'b0, fin_q};
   assign level     = (level_sum > (DivNumW + 1)'(LevelMax)) ? 8'hFF : level_sum[7:0];
   assign step_new  = rising_ff ? (step_ff + 1'b1) : (step_ff - 1'b1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      period_in     = period_ff;
      pwm_in        = pwm_ff;
      wait_in       = wait_ff;
      count_in      = count_ff;
      due_in        = due_ff;
      step_in       = step_ff;
      rising_in     = rising_ff;
      flicker_in    = flicker_ff;
      ch_in         = ch_ff;
      half_in       = half_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      prod_in       = prod_ff;
      bcolor_in     = bcolor_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      black_in      = black_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      div_start     = 1'b0;
      finish        = 1'b0;
      fin_q         = '0;

      // register writes; mode and breath register writes restart the ramp
      if (csr_acc) begin
         case (csr_index)
            CSR_EFFECT_MODE: mode_in   = csr_data[1:0];
            CSR_BREATH_MIN:  min_in    = csr_data[ColorW-1:0];
            CSR_BREATH_MAX:  max_in    = csr_data[ColorW-1:0];
            CSR_BREATH_PER:  period_in = csr_data[19:0];
            CSR_PWM_LEVELS:  pwm_in    = csr_data[15:0];
            CSR_STEP_WAIT:   wait_in   = csr_data[15:0];
            CSR_LED_COUNT:   count_in  = csr_data[3:0];
            default: ;
         endcase
         if (csr_index inside {CSR_EFFECT_MODE, CSR_BREATH_MIN, CSR_BREATH_MAX,
                               CSR_BREATH_PER, CSR_PWM_LEVELS}) begin
            step_in   = '0;
            rising_in = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_word.command == CMD_TICK) && tick_due) begin
               due_in   = due_next;
               n_in     = leds_use;
               cnt_in   = '0;
               black_in = 1'b0;
               case (mode_ff)
                  FX_BREATH: begin
                     half_in  = half_calc;
                     phase_in = PH_LO;
                     ch_in    = '0;
                     state_in = S_MUL;
                  end
                  FX_FLICKER: begin
                     black_in   = !flicker_ff;
                     flicker_in = !flicker_ff;
                     state_in   = S_EMIT;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_MUL: begin
            if (phase_ff == PH_RAMP) begin
               if (half_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  prod_in  = mul_res;
                  state_in = S_LAUNCH;
               end
            end else begin
               prod_in  = mul_res;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (phase_ff == PH_LO) begin
               lo_in    = lvl_scaled;
               phase_in = PH_HI;
            end else begin
               hi_in    = lvl_scaled;
               phase_in = PH_RAMP;
            end
            state_in = S_MUL;
         end
         S_LAUNCH: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               finish = 1'b1;
               fin_q  = div_quo;
            end
         end
         S_EMIT: begin
            rsp_strobe_in          = 1'b1;
            rsp_word_in.out_index  = LedIdxW'(cnt_ff);
            rsp_word_in.frame_last = emit_last;
            if (black_ff) begin
               rsp_word_in.out_color = '0;
            end else if (mode_ff == FX_BREATH) begin
               rsp_word_in.out_color = bcolor_ff;
            end else begin
               rsp_word_in.out_color = cell_color[0];
            end
            if (emit_last) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // channel done: store level, move on or start the frame
      if (finish) begin
         case (ch_ff)
            2'd0:    bcolor_in[23:16] = level;
            2'd1:    bcolor_in[15:8]  = level;
            default: bcolor_in[7:0]   = level;
         endcase
         if (ch_ff == LastChan) begin
            step_in = step_new;
            if (rising_ff) begin
               if ({1'b0, step_new} >= half_ff) begin
                  rising_in = 1'b0;
               end
            end else if (step_new == '0) begin
               rising_in = 1'b1;
            end
            cnt_in   = '0;
            black_in = 1'b0;
            state_in = S_EMIT;
         end else begin
            ch_in    = ch_ff + 1'b1;
            phase_in = PH_LO;
            state_in = S_MUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_LO;
         mode_ff       <= FX_STATIC;
         min_ff        <= '0;
         max_ff        <= '0;
         period_ff     <= 20'd1000;
         pwm_ff        <= 16'd255;
         wait_ff       <= '0;
         count_ff      <= 4'd1;
         due_ff        <= '0;
         step_ff       <= '0;
         rising_ff     <= 1'b1;
         flicker_ff    <= 1'b0;
         ch_ff         <= '0;
         n_ff          <= LedCntW'(1);
         cnt_ff        <= '0;
         black_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         period_ff     <= period_in;
         pwm_ff        <= pwm_in;
         wait_ff       <= wait_in;
         count_ff      <= count_in;
         due_ff        <= due_in;
         step_ff       <= step_in;
         rising_ff     <= rising_in;
         flicker_ff    <= flicker_in;
         ch_ff         <= ch_in;
         n_ff          <= n_in;
         cnt_ff        <= cnt_in;
         black_ff      <= black_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      half_ff     <= half_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      prod_ff     <= prod_in;
      bcolor_ff   <= bcolor_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // ring of led cells
   for (genvar i = 0; i < MaxLeds; i++) begin : g_cell
      logic [ColorW-1:0] next_color;

      if (i == MaxLeds - 1) begin : g_end
         assign next_color = wrap_color;
      end else begin : g_mid
         assign next_color = cell_color[i+1];
      end

      assign cell_ctl[i].load    = write_acc && (int'(req_word.led_index) == i);
      assign cell_ctl[i].shift   = emit_shift && (int'(n_ff) > i);
      assign cell_ctl[i].is_last = (int'(n_ff) == i + 1);

      lsee_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .wr_color   (req_word.led_color),
         .next_color (next_color),
         .wrap_color (wrap_color),
         .color      (cell_color[i])
      );
   end

   lsee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // a result word only follows a frame cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("result word outside a frame");

   // the last word of a frame is followed by a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.frame_last) |=> !rsp_strobe)
      else $error("word right after frame end");

   // divider answers only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider done outside wait");

   // idle block has an idle divider
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_stat.busy)
      else $error("divider running while idle");

endmodule

`default_nettype wire

// File: rtl/lsee_cell.sv
`default_nettype none

module lsee_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lsee_pkg::cell_ctl_type        ctl,
   input  logic [lsee_pkg::ColorW-1:0]   wr_color,
   input  logic [lsee_pkg::ColorW-1:0]   next_color,
   input  logic [lsee_pkg::ColorW-1:0]   wrap_color,
   output logic [lsee_pkg::ColorW-1:0]   color
);
   import lsee_pkg::*;

   logic [ColorW-1:0] color_ff;
   logic [ColorW-1:0] color_in;

   // direct write, ring shift from the neighbor, or hold
   always_comb begin
      color_in = color_ff;
      if (ctl.load) begin
         color_in = wr_color;
      end else if (ctl.shift) begin
         color_in = ctl.is_last ? wrap_color : next_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

`default_nettype wire

// File: rtl/lsee_div.sv
`default_nettype none

module lsee_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lsee_pkg::DivNumW-1:0]   dividend,
   input  logic [lsee_pkg::DivDenW-1:0]   divisor,
   output logic [lsee_pkg::DivNumW-1:0]   quotient,
   output lsee_pkg::div_stat_type         stat
);
   import lsee_pkg::*;

   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivDenW:0]   trial;
   logic [DivDenW:0]   diff;
   logic               fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[DivNumW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = DivCntW'(DivNumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
         quo_in = {quo_ff[DivNumW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
   import lsee_pkg::*;

   localparam int StallLimit   = 3000;
   localparam int SettleCycles = 20;
   localparam int PhaseCount   = 9;
   localparam int PhaseWords   = 18;

   // register index past the end of the map, writes to it are dropped
   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 3'd7;

   // shadow of the strip state plus the queue of led words still owed
   class strip_scoreboard;
      logic [1:0]         mode;
      logic [ColorW-1:0]  floor_rgb;
      logic [ColorW-1:0]  peak_rgb;
      logic [19:0]        period_ms;
      logic [15:0]        pwm_levels;
      logic [15:0]        step_wait;
      logic [3:0]         led_count;
      logic [ColorW-1:0]  colors [MaxLeds];
      logic [TimeW-1:0]   due_ms;
      logic [15:0]        ramp_step;
      bit                 ramp_up;
      bit                 flicker_lit;
      rsp_word_type       pending_leds [$];
      int                 mismatches;

      function new();
         mode        = FX_STATIC;
         floor_rgb   = '0;
         peak_rgb    = '0;
         period_ms   = 20'd1000;
         pwm_levels  = 16'd255;
         step_wait   = '0;
         led_count   = 4'd1;
         foreach (colors[i]) colors[i] = '0;
         due_ms      = '0;
         ramp_step   = '0;
         ramp_up     = 1'b1;
         flicker_lit = 1'b0;
         mismatches  = 0;
      endfunction

      function void set_register(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            CSR_EFFECT_MODE: mode       = data[1:0];
            CSR_BREATH_MIN:  floor_rgb  = data[ColorW-1:0];
            CSR_BREATH_MAX:  peak_rgb   = data[ColorW-1:0];
            CSR_BREATH_PER:  period_ms  = data[19:0];
            CSR_PWM_LEVELS:  pwm_levels = data[15:0];
            CSR_STEP_WAIT:   step_wait  = data[15:0];
            CSR_LED_COUNT:   led_count  = data[3:0];
            default: ;
         endcase
         // mode and breath shape writes restart the ramp
         if (idx <= CSR_PWM_LEVELS) begin
            ramp_step = '0;
            ramp_up   = 1'b1;
         end
      endfunction

      // count 0 means one led, anything past the strip means the whole strip
      function int leds_in_use();
         if (led_count == 0) return 1;
         if (led_count > MaxLeds) return MaxLeds;
         return int'(led_count);
      endfunction

      function void push_frame(int n, bit dark);
         rsp_word_type w;
         for (int k = 0; k < n; k++) begin
            w.out_index  = LedIdxW'(k);
            w.out_color  = dark ? '0 : colors[k];
            w.frame_last = (k == n - 1);
            pending_leds.push_back(w);
         end
      endfunction

      function void take_command(req_word_type w);
         int                n;
         logic [TimeW-1:0]  now;
         logic [31:0]       half;
         logic [ColorW-1:0] shade;
         logic [ColorW-1:0] last;
         logic [7:0]        mn;
         logic [7:0]        mx;
         logic [63:0]       lo;
         logic [63:0]       hi;
         logic [63:0]       lvl;
         n     = leds_in_use();
         now   = w.now_ms;
         half  = 32'(period_ms) / 32'(HalfStepDiv);
         shade = '0;
         if (w.command == CMD_WRITE) begin
            if (w.led_index < MaxLeds) colors[w.led_index] = w.led_color;
            return;
         end
         case (mode)
            FX_STATIC: begin
               if (due_ms < now) begin
                  due_ms = now + StaticWaitMs;
                  push_frame(n, 1'b0);
               end
            end
            FX_BREATH: begin
               if (due_ms + BreathFrameMs < now) begin
                  due_ms = now;
                  // per channel level between scaled min and max
                  for (int c = 0; c < 3; c++) begin
                     mn = floor_rgb[16 - 8 * c +: 8];
                     mx = peak_rgb[16 - 8 * c +: 8];
                     if (mx < mn) mx = LevelMax[7:0];
                     lo  = 64'(pwm_levels) * 64'(mn) / 64'(LevelMax);
                     hi  = 64'(pwm_levels) * 64'(mx) / 64'(LevelMax);
                     lvl = lo;
                     if (half != 0) lvl = lvl + 64'(ramp_step) * (hi - lo) / 64'(half);
                     if (lvl > 64'(LevelMax)) lvl = 64'(LevelMax);
                     shade[16 - 8 * c +: 8] = lvl[7:0];
                  end
                  for (int i = 0; i < n; i++) colors[i] = shade;
                  if (ramp_up) begin
                     ramp_step = ramp_step + 16'd1;
                     if (32'(ramp_step) >= half) ramp_up = 1'b0;
                  end else begin
                     ramp_step = ramp_step - 16'd1;
                     if (ramp_step == 0) ramp_up = 1'b1;
                  end
                  push_frame(n, 1'b0);
               end
            end
            FX_WATERFALL: begin
               if (due_ms + TimeW'(step_wait) < now) begin
                  due_ms = now;
                  push_frame(n, 1'b0);
                  // rotate the leds in use one place up
                  last = colors[n - 1];
                  for (int i = n - 1; i > 0; i--) colors[i] = colors[i - 1];
                  colors[0] = last;
               end
            end
            default: begin
               if (due_ms < now) begin
                  due_ms = now + TimeW'(step_wait);
                  push_frame(n, !flicker_lit);
                  flicker_lit = !flicker_lit;
               end
            end
         endcase
      endfunction

      function void check_led_word(rsp_word_type got);
         rsp_word_type want;
         if (pending_leds.size() == 0) begin
            $display("%0t: unexpected led word index %0d color %06h last %0b",
                     $time, got.out_index, got.out_color, got.frame_last);
            mismatches++;
            return;
         end
         want = pending_leds.pop_front();
         if (got.out_index !== want.out_index) begin
            $display("%0t: out_index expected %0d, got %0d",
                     $time, want.out_index, got.out_index);
            mismatches++;
         end
         if (got.out_color !== want.out_color) begin
            $display("%0t: out_color expected %06h, got %06h",
                     $time, want.out_color, got.out_color);
            mismatches++;
         end
         if (got.frame_last !== want.frame_last) begin
            $display("%0t: frame_last expected %0b, got %0b",
                     $time, want.frame_last, got.frame_last);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic                busy;
   req_word_type        req_word   = '0;
   logic                rsp_strobe;
   rsp_word_type        rsp_word;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0] csr_data   = '0;

   strip_scoreboard board;
   int              stall_cycles = 0;
   bit              steady       = 1'b0;

   led_strip_effect_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every strobed word is taken and checked
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_led_word(rsp_word);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic issue_word(req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         csr_valid <= 1'b0;
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      board.take_command(w);
   endtask

   task automatic tick(logic [TimeW-1:0] now);
      req_word_type w;
      w.command   = CMD_TICK;
      w.now_ms    = now;
      w.led_index = LedIdxW'($urandom);
      w.led_color = ColorW'($urandom);
      issue_word(w);
   endtask

   task automatic paint(logic [LedIdxW-1:0] idx, logic [ColorW-1:0] color);
      req_word_type w;
      w.command   = CMD_WRITE;
      w.now_ms    = $urandom;
      w.led_index = idx;
      w.led_color = color;
      issue_word(w);
   endtask

   // stop sending until every owed word is out, then let the block settle
   task automatic drain();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      while (board.pending_leds.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, data);
   endtask

   initial begin
      logic [TimeW-1:0] margin;
      logic [TimeW-1:0] now;
      logic [1:0]       effect_order [4];
      int               roll;
      board = new();
      effect_order = '{FX_BREATH, FX_WATERFALL, FX_FLICKER, FX_STATIC};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults: static, one led, black list; first tick equals due time
      tick(32'd0);
      tick(32'd1);
      paint(4'd0, 24'hFFFFFF);
      paint(4'd5, 24'h123456);
      paint(4'd12, 24'hABCDEF);
      paint(4'd15, 24'h00FF00);
      tick(32'd302);

      // oversize led count, time at its top so the due time wraps
      drain();
      write_reg(CSR_LED_COUNT, 24'd15);
      tick(32'hFFFF_FFFF);
      tick(32'd300);

      // waterfall with the longest wait, boundary tick first
      drain();
      write_reg(CSR_LED_COUNT, 24'd3);
      write_reg(CSR_STEP_WAIT, 24'hFFFF);
      write_reg(CSR_EFFECT_MODE, 24'(FX_WATERFALL));
      tick(board.due_ms + 32'hFFFF);
      tick(board.due_ms + 32'h1_0000);
      tick(board.due_ms + 32'h1_0000);

      // flicker, zero wait, led count zero
      drain();
      write_reg(CSR_STEP_WAIT, 24'd0);
      write_reg(CSR_LED_COUNT, 24'd0);
      write_reg(CSR_EFFECT_MODE, 24'(FX_FLICKER));
      repeat (3) tick(board.due_ms + 32'd1);

      // breath with period too short for a ramp
      drain();
      write_reg(CSR_BREATH_MIN, 24'h000000);
      write_reg(CSR_BREATH_MAX, 24'hFFFFFF);
      write_reg(CSR_BREATH_PER, 24'd5);
      write_reg(CSR_PWM_LEVELS, 24'hFFFF);
      write_reg(CSR_LED_COUNT, 24'd12);
      write_reg(CSR_EFFECT_MODE, 24'(FX_BREATH));
      repeat (2) tick(board.due_ms + BreathFrameMs + 32'd1);

      // breath ramp, middle channel max below min, dropped register write
      drain();
      write_reg(CSR_BREATH_MIN, 24'h10FF20);
      write_reg(CSR_BREATH_MAX, 24'h8000F0);
      write_reg(CSR_BREATH_PER, 24'd30);
      write_reg(CSR_PWM_LEVELS, 24'd300);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      repeat (4) tick(board.due_ms + BreathFrameMs + 32'd1);

      // random phases, each with new settings
      for (int p = 0; p < PhaseCount; p++) begin
         drain();
         steady = (p == 4);
         write_reg(CSR_EFFECT_MODE, 24'(effect_order[p % 4]));
         if ($urandom_range(0, 1) != 0) write_reg(CSR_BREATH_MIN, CsrDataW'($urandom));
         if ($urandom_range(0, 1) != 0) write_reg(CSR_BREATH_MAX, CsrDataW'($urandom));
         if ($urandom_range(0, 1) != 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 2) write_reg(CSR_BREATH_PER, CsrDataW'($urandom_range(0, 9)));
            else if (roll < 9) write_reg(CSR_BREATH_PER, CsrDataW'($urandom_range(10, 150)));
            else write_reg(CSR_BREATH_PER, 24'h0F_FFFF);
         end
         if ($urandom_range(0, 1) != 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 2) write_reg(CSR_PWM_LEVELS, CsrDataW'($urandom_range(0, 1)));
            else if (roll < 4) write_reg(CSR_PWM_LEVELS, 24'hFFFF);
            else write_reg(CSR_PWM_LEVELS, CsrDataW'($urandom_range(2, 2000)));
         end
         if ($urandom_range(0, 1) != 0) begin
            if ($urandom_range(0, 9) < 8)
               write_reg(CSR_STEP_WAIT, CsrDataW'($urandom_range(0, 40)));
            else
               write_reg(CSR_STEP_WAIT, 24'hFFFF);
         end
         if ($urandom_range(0, 1) != 0) write_reg(CSR_LED_COUNT, CsrDataW'($urandom_range(0, 15)));

         for (int k = 0; k < PhaseWords; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) drain();
            if (roll < 25) begin
               paint(LedIdxW'($urandom_range(0, 15)), ColorW'($urandom));
            end else begin
               // aim the tick just past, at or short of the due point
               if (board.mode == FX_BREATH) margin = BreathFrameMs;
               else if (board.mode == FX_WATERFALL) margin = TimeW'(board.step_wait);
               else margin = '0;
               roll = $urandom_range(0, 99);
               if (roll < 70) now = board.due_ms + margin + TimeW'($urandom_range(1, 8));
               else if (roll < 90) now = board.due_ms + margin - TimeW'($urandom_range(0, 2));
               else now = $urandom;
               tick(now);
            end
         end
      end

      drain();
      if (board.mismatches == 0 && board.pending_leds.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/lsee_pkg.sv
rtl/lsee_cell.sv
rtl/lsee_div.sv
rtl/led_strip_effect_engine_unit.sv
verif/tb_top.sv
